### rtl/lphi_pkg.sv
package lphi_pkg;

    localparam int KEY_W              = 31;
    localparam int TABLE_SIZE_W       = 11;
    localparam int SLOT_W             = 10;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [TABLE_SIZE_W-1:0] RESET_TABLE_SIZE = 11'd1024;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    localparam logic signed [31:0] READ_EMPTY = 32'shFFFF_FFFF;

    typedef struct packed {
        logic [1:0]        mode;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  placed_slot;
        logic signed [31:0] read_value;
    } t_out_item;

endpackage

### rtl/linear_probing_hash_insert.sv
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_in  (lphi_pkg::t_in_item)
// out      output     o_out_valid / i_out_ready  o_out (lphi_pkg::t_out_item)
// cfg      input      i_cfg_we                   i_cfg_wdata (table_size)
//
// One item at a time. Insert: accept, bit-serial key mod table_size, then for each
// probed slot a RAM read and a check, then emit. Read: RAM read, check, emit; an
// out-of-range read or unused mode skips to emit. Clear: all TABLE_DEPTH slots, then
// emit. After reset a clearing pass over all slots runs before the first item.
// A full output register stalls only the emit step; the next item waits for it.
module linear_probing_hash_insert #(
    parameter int TABLE_DEPTH = lphi_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  lphi_pkg::t_in_item                    i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output lphi_pkg::t_out_item                   o_out,
    input  logic                                  i_cfg_we,
    input  logic [lphi_pkg::TABLE_SIZE_W-1:0]     i_cfg_wdata
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int SW  = (AW + 1 > lphi_pkg::TABLE_SIZE_W) ? AW + 1 : lphi_pkg::TABLE_SIZE_W;
    localparam int KW  = lphi_pkg::KEY_W;
    localparam int DCW = $clog2(KW);
    localparam int RW  = KW + 1;

    localparam logic [SW-1:0]  DEPTH_W   = SW'(TABLE_DEPTH);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [DCW-1:0] DIV_LAST  = DCW'(KW - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_READ_RD,
        S_READ_CHK,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic                  r_clr_report, n_clr_report;
    logic [KW-1:0]         r_key, n_key;
    logic [KW-1:0]         r_div_sh, n_div_sh;
    logic [DCW-1:0]        r_div_cnt, n_div_cnt;
    logic [SW-1:0]         r_rem, n_rem;
    logic [SW-1:0]         r_idx, n_idx;
    logic [SW-1:0]         r_probes, n_probes;
    lphi_pkg::t_out_item   r_res, n_res;
    lphi_pkg::t_out_item   r_out, n_out;
    logic                  r_out_vld, n_out_vld;
    logic [lphi_pkg::TABLE_SIZE_W-1:0] r_table_size, n_table_size;

    logic [SW-1:0] ts_w, eff_size;
    logic [SW:0]   div_trial;
    logic          div_ge;
    logic [SW-1:0] idx_inc, probes_inc, sidx_w;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata, ram_rdata;

    lphi_ram #(
        .WIDTH(RW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        ts_w = SW'(r_table_size);
        if (ts_w == '0) begin
            eff_size = SW'(1);
        end else if (ts_w > DEPTH_W) begin
            eff_size = DEPTH_W;
        end else begin
            eff_size = ts_w;
        end
    end

    assign div_trial  = {r_rem, r_div_sh[KW-1]};
    assign div_ge     = div_trial >= {1'b0, eff_size};
    assign idx_inc    = r_idx + 1'b1;
    assign probes_inc = r_probes + 1'b1;
    assign sidx_w     = SW'(i_in.slot_index);
    assign out_free   = !r_out_vld || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_clr_report = r_clr_report;
        n_key        = r_key;
        n_div_sh     = r_div_sh;
        n_div_cnt    = r_div_cnt;
        n_rem        = r_rem;
        n_idx        = r_idx;
        n_probes     = r_probes;
        n_res        = r_res;
        n_out        = r_out;
        n_out_vld    = r_out_vld;
        n_table_size = i_cfg_we ? i_cfg_wdata : r_table_size;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[AW-1:0];
        ram_wdata    = {1'b1, r_key};

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_res      = '{status: lphi_pkg::ST_CLEARED, placed_slot: '0,
                                   read_value: '0};
                    n_state    = r_clr_report ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res = '{status: lphi_pkg::ST_READ, placed_slot: '0,
                              read_value: lphi_pkg::READ_EMPTY};
                    case (i_in.mode)
                        lphi_pkg::MODE_CLEAR: begin
                            n_clr_addr   = '0;
                            n_clr_report = 1'b1;
                            n_state      = S_CLR;
                        end
                        lphi_pkg::MODE_INSERT: begin
                            n_key     = i_in.key;
                            n_div_sh  = i_in.key;
                            n_div_cnt = '0;
                            n_rem     = '0;
                            n_state   = S_DIV;
                        end
                        lphi_pkg::MODE_READ: begin
                            if (sidx_w < eff_size) begin
                                n_idx   = sidx_w;
                                n_state = S_READ_RD;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem     = div_ge ? SW'(div_trial - {1'b0, eff_size}) : div_trial[SW-1:0];
                n_div_sh  = {r_div_sh[KW-2:0], 1'b0};
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_idx    = div_ge ? SW'(div_trial - {1'b0, eff_size})
                                      : div_trial[SW-1:0];
                    n_probes = '0;
                    n_state  = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!ram_rdata[KW]) begin
                    ram_we  = 1'b1;
                    n_res   = '{status: lphi_pkg::ST_PLACED,
                                placed_slot: r_idx[lphi_pkg::SLOT_W-1:0],
                                read_value: '0};
                    n_state = S_EMIT;
                end else if (probes_inc == eff_size) begin
                    n_res   = '{status: lphi_pkg::ST_DROPPED, placed_slot: '0,
                                read_value: '0};
                    n_state = S_EMIT;
                end else begin
                    n_probes = probes_inc;
                    n_idx    = (idx_inc == eff_size) ? '0 : idx_inc;
                    n_state  = S_PROBE_RD;
                end
            end
            S_READ_RD: begin
                n_state = S_READ_CHK;
            end
            S_READ_CHK: begin
                if (ram_rdata[KW]) begin
                    n_res.read_value = $signed({1'b0, ram_rdata[KW-1:0]});
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_out_vld    <= 1'b0;
            r_table_size <= lphi_pkg::RESET_TABLE_SIZE;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_report <= n_clr_report;
            r_out_vld    <= n_out_vld;
            r_table_size <= n_table_size;
        end
        r_key     <= n_key;
        r_div_sh  <= n_div_sh;
        r_div_cnt <= n_div_cnt;
        r_rem     <= n_rem;
        r_idx     <= n_idx;
        r_probes  <= n_probes;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

### rtl/lphi_ram.sv
module lphi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
